[src/s0pem_pkg.sv]
package s0pem_pkg;

  localparam int MAX_METERS     = 8;
  localparam int NUM_METERS_DEF = 8;

  localparam int KW = 22;
  localparam logic [KW-1:0] WH_PER_MS = 22'd3600000;
  localparam logic [31:0]   DECAY_MS  = 32'd10000;

  localparam logic [3:0]  ACTIVE_RST  = 4'd8;
  localparam logic [31:0] PIN_MAP_RST = 32'd0;
  localparam logic [11:0] MIN_PW_RST  = 12'd10;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_PIN_MAP = 2'd1;
  localparam logic [1:0] REG_MIN_PW = 2'd2;

  localparam logic [2:0] ACT_PULSE   = 3'd0;
  localparam logic [2:0] ACT_UPDATE  = 3'd1;
  localparam logic [2:0] ACT_RST_ONE = 3'd2;
  localparam logic [2:0] ACT_RST_ALL = 3'd3;
  localparam logic [2:0] ACT_QUERY   = 3'd4;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_PULSE   = 4'd2;
  localparam logic [3:0] OP_DIV_PER = 4'd3;
  localparam logic [3:0] OP_DIV_MIN = 4'd4;
  localparam logic [3:0] OP_WR_SAT  = 4'd5;
  localparam logic [3:0] OP_INC     = 4'd6;
  localparam logic [3:0] OP_SET_LIM = 4'd7;
  localparam logic [3:0] OP_CAP     = 4'd8;
  localparam logic [3:0] OP_ZERO    = 4'd9;
  localparam logic [3:0] OP_EMIT    = 4'd10;
  localparam logic [3:0] OP_CLR     = 4'd11;
  localparam logic [3:0] OP_EMITQ   = 4'd12;

  localparam logic [3:0] C_NEXT       = 4'd0;
  localparam logic [3:0] C_ALWAYS     = 4'd1;
  localparam logic [3:0] C_DISPATCH   = 4'd2;
  localparam logic [3:0] C_I_EQ_N     = 4'd3;
  localparam logic [3:0] C_PIN_NE     = 4'd4;
  localparam logic [3:0] C_PER_ZERO   = 4'd5;
  localparam logic [3:0] C_DIV_BUSY   = 4'd6;
  localparam logic [3:0] C_PER_GT_LIM = 4'd7;
  localparam logic [3:0] C_PER_LE_DEC = 4'd8;
  localparam logic [3:0] C_OUT_FULL   = 4'd9;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_P_TOP   = 5'd1;
  localparam logic [4:0] ST_P_HIT   = 5'd2;
  localparam logic [4:0] ST_P_DIV   = 5'd3;
  localparam logic [4:0] ST_P_WAIT  = 5'd4;
  localparam logic [4:0] ST_P_WR    = 5'd5;
  localparam logic [4:0] ST_P_NEXT  = 5'd6;
  localparam logic [4:0] ST_U_LIM   = 5'd7;
  localparam logic [4:0] ST_U_LWAIT = 5'd8;
  localparam logic [4:0] ST_U_LSET  = 5'd9;
  localparam logic [4:0] ST_U_TOP   = 5'd10;
  localparam logic [4:0] ST_U_CHK   = 5'd11;
  localparam logic [4:0] ST_U_DIV   = 5'd12;
  localparam logic [4:0] ST_U_WAIT  = 5'd13;
  localparam logic [4:0] ST_U_CAP   = 5'd14;
  localparam logic [4:0] ST_U_ZERO  = 5'd15;
  localparam logic [4:0] ST_U_EMIT  = 5'd16;
  localparam logic [4:0] ST_U_NEXT  = 5'd17;
  localparam logic [4:0] ST_R1      = 5'd18;
  localparam logic [4:0] ST_RA_TOP  = 5'd19;
  localparam logic [4:0] ST_RA_NEXT = 5'd20;
  localparam logic [4:0] ST_Q_EMIT  = 5'd21;
  localparam logic [4:0] ST_Q_DONE  = 5'd22;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] cond;
    logic [4:0] target;
  } ucw_t;

  function automatic ucw_t ucode(input logic [4:0] step);
    ucw_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: ST_IDLE};
    case (step)
      ST_IDLE:    w = '{op: OP_NONE,    cond: C_DISPATCH,   target: ST_IDLE};
      ST_P_TOP:   w = '{op: OP_LOAD,    cond: C_I_EQ_N,     target: ST_IDLE};
      ST_P_HIT:   w = '{op: OP_PULSE,   cond: C_PIN_NE,     target: ST_P_NEXT};
      ST_P_DIV:   w = '{op: OP_DIV_PER, cond: C_PER_ZERO,   target: ST_P_NEXT};
      ST_P_WAIT:  w = '{op: OP_NONE,    cond: C_DIV_BUSY,   target: ST_P_WAIT};
      ST_P_WR:    w = '{op: OP_WR_SAT,  cond: C_NEXT,       target: ST_IDLE};
      ST_P_NEXT:  w = '{op: OP_INC,     cond: C_ALWAYS,     target: ST_P_TOP};
      ST_U_LIM:   w = '{op: OP_DIV_MIN, cond: C_NEXT,       target: ST_IDLE};
      ST_U_LWAIT: w = '{op: OP_NONE,    cond: C_DIV_BUSY,   target: ST_U_LWAIT};
      ST_U_LSET:  w = '{op: OP_SET_LIM, cond: C_NEXT,       target: ST_IDLE};
      ST_U_TOP:   w = '{op: OP_LOAD,    cond: C_I_EQ_N,     target: ST_IDLE};
      ST_U_CHK:   w = '{op: OP_NONE,    cond: C_PER_GT_LIM, target: ST_U_ZERO};
      ST_U_DIV:   w = '{op: OP_DIV_PER, cond: C_PER_LE_DEC, target: ST_U_EMIT};
      ST_U_WAIT:  w = '{op: OP_NONE,    cond: C_DIV_BUSY,   target: ST_U_WAIT};
      ST_U_CAP:   w = '{op: OP_CAP,     cond: C_ALWAYS,     target: ST_U_EMIT};
      ST_U_ZERO:  w = '{op: OP_ZERO,    cond: C_NEXT,       target: ST_IDLE};
      ST_U_EMIT:  w = '{op: OP_EMIT,    cond: C_OUT_FULL,   target: ST_U_EMIT};
      ST_U_NEXT:  w = '{op: OP_INC,     cond: C_ALWAYS,     target: ST_U_TOP};
      ST_R1:      w = '{op: OP_CLR,     cond: C_ALWAYS,     target: ST_IDLE};
      ST_RA_TOP:  w = '{op: OP_CLR,     cond: C_I_EQ_N,     target: ST_IDLE};
      ST_RA_NEXT: w = '{op: OP_INC,     cond: C_ALWAYS,     target: ST_RA_TOP};
      ST_Q_EMIT:  w = '{op: OP_EMITQ,   cond: C_OUT_FULL,   target: ST_Q_EMIT};
      ST_Q_DONE:  w = '{op: OP_NONE,    cond: C_ALWAYS,     target: ST_IDLE};
      default:    w = '{op: OP_NONE,    cond: C_ALWAYS,     target: ST_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] entry(input logic [2:0] action);
    logic [4:0] s;
    case (action)
      ACT_PULSE:   s = ST_P_TOP;
      ACT_UPDATE:  s = ST_U_LIM;
      ACT_RST_ONE: s = ST_R1;
      ACT_RST_ALL: s = ST_RA_TOP;
      ACT_QUERY:   s = ST_Q_EMIT;
      default:     s = ST_IDLE;
    endcase
    return s;
  endfunction

endpackage

[src/s0pem_if.sv]
interface s0pem_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  meter_index;
  logic [3:0]  pin_number;
  logic [31:0] now_ms;

  modport source (output valid, action, meter_index, pin_number, now_ms, input ready);
  modport sink (input valid, action, meter_index, pin_number, now_ms, output ready);
endinterface

interface s0pem_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  meter_index_res;
  logic [15:0] energy_wh;
  logic [15:0] power_w;
  logic        last;

  modport source (output valid, meter_index_res, energy_wh, power_w, last, input ready);
  modport sink (input valid, meter_index_res, energy_wh, power_w, last, output ready);
endinterface

[src/s0_pulse_energy_meter_unit.sv]
// Channel   Dir  Word
// item      in   action, meter_index, pin_number, now_ms
// result    out  meter_index_res, energy_wh, power_w, last
// cfg_*     in   cfg_we, cfg_index, cfg_data (write only)
//
// One item at a time; item.ready is high only while the sequencer sits in its idle step.
// Pulse and update walk the n active meters; update first divides once to set its power limit.
// Each division runs 22 restoring steps, one quotient bit per cycle.
// Query emits one result; reset one clears a single meter, reset all clears each active meter in turn.
// A stalled result holds the sequencer at its emit step; reset is synchronous, no clear pass.
module s0_pulse_energy_meter_unit #(
  parameter int NUM_METERS = s0pem_pkg::NUM_METERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  s0pem_in_if.sink           item,
  s0pem_out_if.source        result,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int NM = (NUM_METERS > s0pem_pkg::MAX_METERS) ? s0pem_pkg::MAX_METERS
                                                            : NUM_METERS;
  localparam int IW = (NM > 1) ? $clog2(NM) : 1;
  localparam logic [3:0] NM_V = 4'(NM);
  localparam int KW = s0pem_pkg::KW;

  logic [3:0]  active;
  logic [31:0] pin_map;
  logic [11:0] min_pw;

  logic [15:0] energy [NM];
  logic [15:0] power  [NM];
  logic [31:0] lpt    [NM];

  logic [4:0]  step;
  logic [4:0]  step_next;
  logic [3:0]  i;
  logic [3:0]  pin_q;
  logic [31:0] now_q;
  logic [31:0] period;
  logic [KW-1:0] limit;

  logic          div_busy;
  logic [4:0]    div_cnt;
  logic [KW-1:0] div_q;
  logic [31:0]   div_r;
  logic [31:0]   div_d;
  logic [32:0]   div_t;
  logic [33:0]   div_diff;
  logic          div_ge;
  logic          div_start;
  logic [31:0]   divisor;

  logic          ovalid;
  logic [2:0]    o_idx;
  logic [15:0]   o_wh;
  logic [15:0]   o_w;
  logic          o_last;

  s0pem_pkg::ucw_t cw;
  logic        taken;
  logic        exec;
  logic        accept;
  logic        out_free;
  logic [3:0]  n_act;
  logic [11:0] minp;
  logic [IW-1:0] ix;
  logic        in_range;
  logic        pin_hit;
  logic [15:0] sat_q;

  assign accept   = item.valid && item.ready;
  assign out_free = !ovalid || result.ready;
  assign n_act    = (active > NM_V) ? NM_V : active;
  assign minp     = (min_pw == 12'd0) ? 12'd1 : min_pw;
  assign ix       = i[IW-1:0];
  assign in_range = i < n_act;
  assign pin_hit  = pin_map[{i[2:0], 2'b00} +: 4] == pin_q;
  assign sat_q    = (div_q > KW'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];

  assign item.ready             = step == s0pem_pkg::ST_IDLE;
  assign result.valid           = ovalid;
  assign result.meter_index_res = o_idx;
  assign result.energy_wh       = o_wh;
  assign result.power_w         = o_w;
  assign result.last            = o_last;

  always_comb begin
    cw = s0pem_pkg::ucode(step);
    case (cw.cond)
      s0pem_pkg::C_NEXT:       taken = 1'b0;
      s0pem_pkg::C_ALWAYS:     taken = 1'b1;
      s0pem_pkg::C_DISPATCH:   taken = 1'b0;
      s0pem_pkg::C_I_EQ_N:     taken = i == n_act;
      s0pem_pkg::C_PIN_NE:     taken = !pin_hit;
      s0pem_pkg::C_PER_ZERO:   taken = period == 32'd0;
      s0pem_pkg::C_DIV_BUSY:   taken = div_busy;
      s0pem_pkg::C_PER_GT_LIM: taken = period > 32'(limit);
      s0pem_pkg::C_PER_LE_DEC: taken = period <= s0pem_pkg::DECAY_MS;
      s0pem_pkg::C_OUT_FULL:   taken = !out_free;
      default:                 taken = 1'b0;
    endcase
    exec = !(taken && cw.cond != s0pem_pkg::C_ALWAYS);
    if (cw.cond == s0pem_pkg::C_DISPATCH) begin
      step_next = accept ? s0pem_pkg::entry(item.action) : step;
    end else if (taken) begin
      step_next = cw.target;
    end else begin
      step_next = step + 5'd1;
    end
  end

  assign div_start = exec && (cw.op inside {s0pem_pkg::OP_DIV_PER, s0pem_pkg::OP_DIV_MIN});
  assign divisor   = (cw.op == s0pem_pkg::OP_DIV_MIN) ? 32'(minp) : period;
  assign div_t     = {div_r, div_q[KW-1]};
  assign div_diff  = {1'b0, div_t} - {2'b00, div_d};
  assign div_ge    = !div_diff[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= s0pem_pkg::ACTIVE_RST;
      pin_map <= s0pem_pkg::PIN_MAP_RST;
      min_pw  <= s0pem_pkg::MIN_PW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        s0pem_pkg::REG_ACTIVE:  active  <= cfg_data[3:0];
        s0pem_pkg::REG_PIN_MAP: pin_map <= cfg_data;
        s0pem_pkg::REG_MIN_PW:  min_pw  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == 5'd0) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_cnt <= 5'(KW - 1);
      div_q   <= s0pem_pkg::WH_PER_MS;
      div_r   <= 32'd0;
      div_d   <= divisor;
    end else if (div_busy) begin
      div_cnt <= div_cnt - 5'd1;
      div_r   <= div_ge ? div_diff[31:0] : div_t[31:0];
      div_q   <= {div_q[KW-2:0], div_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= s0pem_pkg::ST_IDLE;
      i      <= 4'd0;
      ovalid <= 1'b0;
      for (int k = 0; k < NM; k++) begin
        energy[k] <= 16'd0;
        power[k]  <= 16'd0;
        lpt[k]    <= 32'd0;
      end
    end else begin
      step <= step_next;
      if (exec && (cw.op inside {s0pem_pkg::OP_EMIT, s0pem_pkg::OP_EMITQ})) begin
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end
      if (accept) begin
        if (item.action inside {s0pem_pkg::ACT_RST_ONE, s0pem_pkg::ACT_QUERY}) begin
          i <= {1'b0, item.meter_index};
        end else begin
          i <= 4'd0;
        end
      end
      if (exec) begin
        case (cw.op)
          s0pem_pkg::OP_PULSE: begin
            energy[ix] <= energy[ix] + 16'd1;
            lpt[ix]    <= now_q;
          end
          s0pem_pkg::OP_WR_SAT: power[ix] <= sat_q;
          s0pem_pkg::OP_INC:    i <= i + 4'd1;
          s0pem_pkg::OP_CAP: begin
            if (KW'(power[ix]) > div_q) begin
              power[ix] <= div_q[15:0];
            end
          end
          s0pem_pkg::OP_ZERO:   power[ix] <= 16'd0;
          s0pem_pkg::OP_CLR: begin
            if (in_range) begin
              energy[ix] <= 16'd0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin_q <= item.pin_number;
      now_q <= item.now_ms;
    end
    if (exec) begin
      case (cw.op)
        s0pem_pkg::OP_LOAD: begin
          if (in_range) begin
            period <= now_q - lpt[ix];
          end
        end
        s0pem_pkg::OP_SET_LIM: limit <= div_q;
        s0pem_pkg::OP_EMIT: begin
          o_idx  <= i[2:0];
          o_wh   <= energy[ix];
          o_w    <= power[ix];
          o_last <= (i + 4'd1) == n_act;
        end
        s0pem_pkg::OP_EMITQ: begin
          o_idx  <= i[2:0];
          o_wh   <= in_range ? energy[ix] : 16'd0;
          o_w    <= in_range ? power[ix] : 16'd0;
          o_last <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    step == s0pem_pkg::ST_IDLE |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (step == s0pem_pkg::ST_U_EMIT || step == s0pem_pkg::ST_Q_EMIT) && result.valid
    && !result.ready |=> step == $past(step))
    else $error("sequencer left emit step while result stalled");

  a_loop_bound: assert property (@(posedge clk) disable iff (rst)
    (step == s0pem_pkg::ST_P_TOP || step == s0pem_pkg::ST_U_TOP
     || step == s0pem_pkg::ST_RA_TOP) |-> i <= n_act)
    else $error("meter counter ran past active count");

endmodule
